/* hdl/amssb_pkg.sv */
// ----------------------------------------------------------------------------
// amssb_pkg
// Shared types and constants for the AM/SSB detector with DC block and
// block power measurement.
// ----------------------------------------------------------------------------
`default_nettype none

package amssb_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int AUDIO_W   = SAMPLE_W + 1;
   localparam int REQ_W     = 2 * SAMPLE_W;
   localparam int LEVEL_W   = 47;
   localparam int SUM_W     = 48;
   localparam int DC_W      = 32;
   localparam int RSP_W     = 64;
   localparam int MODE_W    = 2;
   localparam int LEN_W     = 13;
   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 1;
   localparam int ACC_W     = 64;
   localparam int OPND_W    = 16;
   localparam int PROD_W    = 2 * OPND_W;
   localparam int FRAC_W    = 16;
   localparam int RAD_W     = 32;
   localparam int ROOT_W    = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DETECT_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LEN   = 1'd1;

   // detect modes
   localparam logic [MODE_W-1:0] MODE_ENV = 2'd0;
   localparam logic [MODE_W-1:0] MODE_USB = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LSB = 2'd2;

   localparam logic [LEN_W-1:0] LEN_RESET = 13'd480;

   // Q0.16 coefficients
   localparam logic [OPND_W-1:0] COEF_DC_KEEP = 16'd64881;
   localparam logic [OPND_W-1:0] COEF_DC_NEW  = 16'd655;
   localparam logic [OPND_W-1:0] COEF_LV_KEEP = 16'd58982;
   localparam logic [OPND_W-1:0] COEF_LV_NEW  = 16'd6554;

   localparam logic [ACC_W-1:0] ACC_HALF = 64'd32768;
   localparam logic [DC_W:0]    DC_HALF  = 33'd32768;

   // product placement in the accumulator
   localparam logic [1:0] SH_0  = 2'd0;
   localparam logic [1:0] SH_16 = 2'd1;
   localparam logic [1:0] SH_32 = 2'd2;

   typedef struct packed {
      logic              valid;
      logic              clear;
      logic              rnd;
      logic [1:0]        shift;
      logic [OPND_W-1:0] a;
      logic [OPND_W-1:0] b;
   } mac_cmd_type;

endpackage

`default_nettype wire

/* hdl/amssb_mac.sv */
// ----------------------------------------------------------------------------
// amssb_mac
// Shared 16x16 unsigned multiply-accumulate unit: product register, then a
// shifted add into a 64-bit accumulator. Result is readable in acc once the last
// command has passed the product register and the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module amssb_mac (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire amssb_pkg::mac_cmd_type      cmd,
   output logic [amssb_pkg::ACC_W-1:0]      acc
);
   import amssb_pkg::*;

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              pv_ff, pv_in;
   logic              pclr_ff, pclr_in;
   logic              prnd_ff, prnd_in;
   logic [1:0]        psh_ff, psh_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  base;
   logic [ACC_W-1:0]  addend;

   assign prod_in = cmd.a * cmd.b;
   assign pv_in   = cmd.valid;
   assign pclr_in = cmd.clear;
   assign prnd_in = cmd.rnd;
   assign psh_in  = cmd.shift;

   always_comb begin
      case (psh_ff)
         SH_0:    addend = {32'd0, prod_ff};
         SH_16:   addend = {16'd0, prod_ff, 16'd0};
         SH_32:   addend = {prod_ff, 32'd0};
         default: addend = {32'd0, prod_ff};
      endcase
      if (pclr_ff) begin
         base = prnd_ff ? ACC_HALF : '0;
      end else begin
         base = acc_ff;
      end
      acc_in = pv_ff ? (base + addend) : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= pv_in;
      end
      prod_ff <= prod_in;
      pclr_ff <= pclr_in;
      prnd_ff <= prnd_in;
      psh_ff  <= psh_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

/* hdl/amssb_sqrt.sv */
// ----------------------------------------------------------------------------
// amssb_sqrt
// Bit-pair restoring integer square root, one compare-subtract per cycle,
// 16 steps for a 32-bit radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module amssb_sqrt (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [amssb_pkg::RAD_W-1:0]  radicand,
   output logic                              done,
   output logic [amssb_pkg::ROOT_W-1:0]      root
);
   import amssb_pkg::*;

   logic [RAD_W-1:0] rem_ff, rem_in;
   logic [RAD_W-1:0] res_ff, res_in;
   logic [RAD_W-1:0] bit_ff, bit_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [RAD_W:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {1'b0, res_ff} + {1'b0, bit_ff};
      if (start) begin
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = RAD_W'(1) << (RAD_W - 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = rem_ff - trial[RAD_W-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         // lowest bit pair is the final step
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

`default_nettype wire

/* hdl/am_ssb_detector_dc_block_top.sv */
// ----------------------------------------------------------------------------
// am_ssb_detector_dc_block_top
// AM envelope / SSB product detector with DC blocking and block power level.
// ----------------------------------------------------------------------------
// One sample is in work at a time; req_tready is high only while the block
// waits for a sample, and a finished result waits in the rsp register so the
// next sample can be taken meanwhile. In envelope mode a sample goes from one
// accepted transfer to the next through the two squares in the one 16x16
// multiply-accumulate unit, the 16-step shared square root, the DC tracker,
// the audio power, the hand-over of the result and the wait for the next
// sample. The sideband modes go straight to the audio power. A sample that
// closes a power block also passes through the level update on the same
// multiplier. While the rsp register still holds an untaken result, the
// hand-over waits for rsp_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module am_ssb_detector_dc_block_top #(
   parameter int MAX_BLOCK = 4096
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata: in_i [15:0], in_q [31:16]
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [amssb_pkg::REQ_W-1:0]      req_tdata,
   // rsp_tdata: audio [16:0], level [63:17]; rsp_tlast: block_end
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [amssb_pkg::RSP_W-1:0]           rsp_tdata,
   output logic                                  rsp_tlast,
   input  wire logic                             csr_we,
   input  wire logic [amssb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [amssb_pkg::CSR_W-1:0]      csr_wdata
);
   import amssb_pkg::*;

   localparam int CNT_W = $clog2(MAX_BLOCK + 1);
   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_ESQ_I    = 5'd1;
   localparam logic [4:0] ST_ESQ_Q    = 5'd2;
   localparam logic [4:0] ST_ESQ_W    = 5'd3;
   localparam logic [4:0] ST_SQRT_GO  = 5'd4;
   localparam logic [4:0] ST_SQRT_RUN = 5'd5;
   localparam logic [4:0] ST_DC0      = 5'd6;
   localparam logic [4:0] ST_DC1      = 5'd7;
   localparam logic [4:0] ST_DC2      = 5'd8;
   localparam logic [4:0] ST_DC_W     = 5'd9;
   localparam logic [4:0] ST_AUD      = 5'd10;
   localparam logic [4:0] ST_SQR      = 5'd11;
   localparam logic [4:0] ST_SQR_W    = 5'd12;
   localparam logic [4:0] ST_SUM      = 5'd13;
   localparam logic [4:0] ST_LV0      = 5'd14;
   localparam logic [4:0] ST_LV1      = 5'd15;
   localparam logic [4:0] ST_LV2      = 5'd16;
   localparam logic [4:0] ST_LV3      = 5'd17;
   localparam logic [4:0] ST_LV4      = 5'd18;
   localparam logic [4:0] ST_LV5      = 5'd19;
   localparam logic [4:0] ST_LV_W     = 5'd20;
   localparam logic [4:0] ST_LV_END   = 5'd21;
   localparam logic [4:0] ST_OUT      = 5'd22;

   logic [4:0]          state_ff, state_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [OPND_W-1:0]   abs_i_ff, abs_i_in;
   logic [OPND_W-1:0]   abs_q_ff, abs_q_in;
   logic [ROOT_W-1:0]   mag_ff, mag_in;
   logic [DC_W-1:0]     dc_ff, dc_in;
   logic [AUDIO_W-1:0]  audio_ff, audio_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic                closed_ff, closed_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   mac_cmd_type         mac_cmd;
   logic [ACC_W-1:0]    acc;
   logic                sqrt_start;
   logic                sqrt_done;
   logic [ROOT_W-1:0]   sqrt_root;

   logic [SAMPLE_W-1:0] in_i;
   logic [SAMPLE_W-1:0] in_q;
   logic [AUDIO_W-1:0]  ext_i;
   logic [AUDIO_W-1:0]  ext_q;
   logic [AUDIO_W-1:0]  neg_i;
   logic [AUDIO_W-1:0]  neg_q;
   logic [AUDIO_W-1:0]  neg_audio;
   logic [OPND_W-1:0]   abs_audio;
   logic [DC_W-1:0]     dc_new;
   logic [DC_W:0]       dc_round;
   logic [AUDIO_W:0]    audio_diff;
   logic [SUM_W:0]      sum_add;
   logic [SUM_W-1:0]    sum_sat;
   logic [CMP_W-1:0]    len_eff;
   logic [CMP_W-1:0]    cnt_next;
   logic [SUM_W-1:0]    level_new;
   logic                out_free;
   logic                req_xfer;

   amssb_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (mac_cmd),
      .acc   (acc)
   );

   amssb_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (acc[RAD_W-1:0]),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign in_i      = req_tdata[SAMPLE_W-1:0];
   assign in_q      = req_tdata[REQ_W-1:SAMPLE_W];
   assign ext_i     = {in_i[SAMPLE_W-1], in_i};
   assign ext_q     = {in_q[SAMPLE_W-1], in_q};
   assign neg_i     = -ext_i;
   assign neg_q     = -ext_q;
   assign neg_audio = -audio_ff;
   assign abs_audio = audio_ff[AUDIO_W-1] ? neg_audio[OPND_W-1:0] : audio_ff[OPND_W-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign sqrt_start = (state_ff == ST_SQRT_GO);

   // effective block length, clamped to one .. MAX_BLOCK
   always_comb begin
      len_eff = CMP_W'(len_ff);
      if (len_ff == '0) begin
         len_eff = CMP_W'(1);
      end else if (CMP_W'(len_ff) > CMP_W'(MAX_BLOCK)) begin
         len_eff = CMP_W'(MAX_BLOCK);
      end
   end

   assign cnt_next = CMP_W'(cnt_ff) + CMP_W'(1);

   assign dc_new     = acc[FRAC_W +: DC_W];
   assign dc_round   = {1'b0, dc_new} + DC_HALF;
   assign audio_diff = {2'b00, mag_ff} - {1'b0, dc_round[DC_W:FRAC_W]};

   assign sum_add   = {1'b0, sum_ff} + {{(SUM_W + 1 - PROD_W){1'b0}}, acc[PROD_W-1:0]};
   assign sum_sat   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
   assign level_new = acc[FRAC_W +: SUM_W];

   // multiply-accumulate command for each step
   always_comb begin
      mac_cmd       = '0;
      mac_cmd.valid = 1'b1;
      case (state_ff)
         ST_ESQ_I: begin
            mac_cmd.clear = 1'b1;
            mac_cmd.a     = abs_i_ff;
            mac_cmd.b     = abs_i_ff;
            mac_cmd.shift = SH_0;
         end
         ST_ESQ_Q: begin
            mac_cmd.a     = abs_q_ff;
            mac_cmd.b     = abs_q_ff;
            mac_cmd.shift = SH_0;
         end
         ST_DC0: begin
            mac_cmd.clear = 1'b1;
            mac_cmd.rnd   = 1'b1;
            mac_cmd.a     = dc_ff[15:0];
            mac_cmd.b     = COEF_DC_KEEP;
            mac_cmd.shift = SH_0;
         end
         ST_DC1: begin
            mac_cmd.a     = dc_ff[31:16];
            mac_cmd.b     = COEF_DC_KEEP;
            mac_cmd.shift = SH_16;
         end
         ST_DC2: begin
            mac_cmd.a     = mag_ff;
            mac_cmd.b     = COEF_DC_NEW;
            mac_cmd.shift = SH_16;
         end
         ST_SQR: begin
            mac_cmd.clear = 1'b1;
            mac_cmd.a     = abs_audio;
            mac_cmd.b     = abs_audio;
            mac_cmd.shift = SH_0;
         end
         ST_LV0: begin
            mac_cmd.clear = 1'b1;
            mac_cmd.rnd   = 1'b1;
            mac_cmd.a     = level_ff[15:0];
            mac_cmd.b     = COEF_LV_KEEP;
            mac_cmd.shift = SH_0;
         end
         ST_LV1: begin
            mac_cmd.a     = level_ff[31:16];
            mac_cmd.b     = COEF_LV_KEEP;
            mac_cmd.shift = SH_16;
         end
         ST_LV2: begin
            mac_cmd.a     = {1'b0, level_ff[46:32]};
            mac_cmd.b     = COEF_LV_KEEP;
            mac_cmd.shift = SH_32;
         end
         ST_LV3: begin
            mac_cmd.a     = sum_ff[15:0];
            mac_cmd.b     = COEF_LV_NEW;
            mac_cmd.shift = SH_0;
         end
         ST_LV4: begin
            mac_cmd.a     = sum_ff[31:16];
            mac_cmd.b     = COEF_LV_NEW;
            mac_cmd.shift = SH_16;
         end
         ST_LV5: begin
            mac_cmd.a     = sum_ff[47:32];
            mac_cmd.b     = COEF_LV_NEW;
            mac_cmd.shift = SH_32;
         end
         default: begin
            mac_cmd.valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      len_in       = len_ff;
      abs_i_in     = abs_i_ff;
      abs_q_in     = abs_q_ff;
      mag_in       = mag_ff;
      dc_in        = dc_ff;
      audio_in     = audio_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      level_in     = level_ff;
      closed_in    = closed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_DETECT_MODE: mode_in = csr_wdata[MODE_W-1:0];
            CSR_BLOCK_LEN:   len_in  = csr_wdata[LEN_W-1:0];
            default:         ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               abs_i_in = in_i[SAMPLE_W-1] ? neg_i[OPND_W-1:0] : in_i;
               abs_q_in = in_q[SAMPLE_W-1] ? neg_q[OPND_W-1:0] : in_q;
               case (mode_ff)
                  MODE_ENV: audio_in = '0;
                  MODE_USB: audio_in = ext_i;
                  MODE_LSB: audio_in = ext_q;
                  default:  audio_in = '0;
               endcase
               state_in = (mode_ff == MODE_ENV) ? ST_ESQ_I : ST_SQR;
            end
         end
         ST_ESQ_I:    state_in = ST_ESQ_Q;
         ST_ESQ_Q:    state_in = ST_ESQ_W;
         ST_ESQ_W:    state_in = ST_SQRT_GO;
         ST_SQRT_GO:  state_in = ST_SQRT_RUN;
         ST_SQRT_RUN: begin
            if (sqrt_done) begin
               mag_in   = sqrt_root;
               state_in = ST_DC0;
            end
         end
         ST_DC0:      state_in = ST_DC1;
         ST_DC1:      state_in = ST_DC2;
         ST_DC2:      state_in = ST_DC_W;
         ST_DC_W:     state_in = ST_AUD;
         ST_AUD: begin
            dc_in    = dc_new;
            audio_in = audio_diff[AUDIO_W-1:0];
            state_in = ST_SQR;
         end
         ST_SQR:      state_in = ST_SQR_W;
         ST_SQR_W:    state_in = ST_SUM;
         ST_SUM: begin
            sum_in = sum_sat;
            if (cnt_next >= len_eff) begin
               state_in = ST_LV0;
            end else begin
               cnt_in    = cnt_next[CNT_W-1:0];
               closed_in = 1'b0;
               state_in  = ST_OUT;
            end
         end
         ST_LV0:      state_in = ST_LV1;
         ST_LV1:      state_in = ST_LV2;
         ST_LV2:      state_in = ST_LV3;
         ST_LV3:      state_in = ST_LV4;
         ST_LV4:      state_in = ST_LV5;
         ST_LV5:      state_in = ST_LV_W;
         ST_LV_W:     state_in = ST_LV_END;
         ST_LV_END: begin
            // level saturates at its 47-bit ceiling
            level_in  = level_new[SUM_W-1] ? {LEVEL_W{1'b1}} : level_new[LEVEL_W-1:0];
            sum_in    = '0;
            cnt_in    = '0;
            closed_in = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {level_ff, audio_ff};
               rsp_last_in  = closed_ff;
               state_in     = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_ENV;
         len_ff       <= LEN_RESET;
         dc_ff        <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         level_ff     <= '0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         len_ff       <= len_in;
         dc_ff        <= dc_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         level_ff     <= level_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      abs_i_ff    <= abs_i_in;
      abs_q_ff    <= abs_q_in;
      mag_ff      <= mag_in;
      audio_ff    <= audio_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the AM/SSB detector with DC block and block power.
// Samples are streamed in with random gaps; a local bit-exact model of the
// magnitude, DC tracker, power sum and level smoother predicts every result,
// and each response transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import amssb_pkg::*;

   localparam int           MAX_BLK     = 4096;
   localparam int           STALL_LIMIT = 4000;
   localparam int           IDLE_PCT    = 14;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [63:0]  SUM_MAX     = (64'd1 << SUM_W) - 64'd1;
   localparam logic [63:0]  LEVEL_MAX   = (64'd1 << LEVEL_W) - 64'd1;
   localparam logic [63:0]  HALF_LSB    = 64'd32768;

   typedef struct packed {
      logic [AUDIO_W-1:0] audio;
      logic               blk_end;
      logic [LEVEL_W-1:0] level;
   } detector_out_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // detector model state and register copies
   logic [MODE_W-1:0]    cfg_mode = MODE_ENV;
   logic [LEN_W-1:0]     cfg_len = LEN_RESET;
   logic [63:0]          dc_q16 = '0;
   logic [63:0]          power_acc = '0;
   logic [63:0]          smooth_pwr = '0;
   int                   block_pos = 0;

   logic [REQ_W-1:0]     pending_samples[$];
   detector_out_type     audio_expected[$];
   int                   loaded_cnt = 0;
   int                   taken_cnt = 0;
   int                   error_cnt = 0;
   int                   stall_cnt = 0;

   am_ssb_detector_dc_block_top #(.MAX_BLOCK(MAX_BLK)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] root;
      logic [63:0] bit_w;
      root  = '0;
      bit_w = 64'd1 << 62;
      while (bit_w > x)
         bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (x >= root + bit_w) begin
            x    = x - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return root;
   endfunction

   // one sample through the detector, dc tracker, power sum and level smoother
   function automatic detector_out_type detect_sample(logic [REQ_W-1:0] smp);
      longint           si;
      longint           sq;
      longint           audio;
      logic [63:0]      mag;
      logic [63:0]      sqr;
      logic [63:0]      nl;
      int               len;
      detector_out_type res;
      si    = longint'($signed(smp[SAMPLE_W-1:0]));
      sq    = longint'($signed(smp[REQ_W-1:SAMPLE_W]));
      audio = 0;
      case (cfg_mode)
         MODE_ENV: begin
            mag    = int_sqrt(64'(si * si + sq * sq));
            dc_q16 = (dc_q16 * 64'(COEF_DC_KEEP) + (mag << FRAC_W) * 64'(COEF_DC_NEW)
                      + HALF_LSB) >> FRAC_W;
            audio  = longint'(mag) - longint'((dc_q16 + HALF_LSB) >> FRAC_W);
         end
         MODE_USB: audio = si;
         MODE_LSB: audio = sq;
         default:  audio = 0;
      endcase
      sqr = 64'(audio * audio);
      if (sqr > SUM_MAX - power_acc)
         power_acc = SUM_MAX;
      else
         power_acc = power_acc + sqr;
      len = int'(cfg_len);
      if (len == 0)
         len = 1;
      if (len > MAX_BLK)
         len = MAX_BLK;
      block_pos++;
      res.blk_end = 1'b0;
      if (block_pos >= len) begin
         nl = (smooth_pwr * 64'(COEF_LV_KEEP) + power_acc * 64'(COEF_LV_NEW)
               + HALF_LSB) >> FRAC_W;
         smooth_pwr  = (nl > LEVEL_MAX) ? LEVEL_MAX : nl;
         power_acc   = '0;
         block_pos   = 0;
         res.blk_end = 1'b1;
      end
      res.audio = audio[AUDIO_W-1:0];
      res.level = smooth_pwr[LEVEL_W-1:0];
      return res;
   endfunction

   // driver: holds each sample until it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_samples.size() != 0 &&
             ((loaded_cnt >= 250 && loaded_cnt < 370) || $urandom_range(99) >= IDLE_PCT)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_samples.pop_front();
            loaded_cnt <= loaded_cnt + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= (taken_cnt >= 260 && taken_cnt < 380) ||
                       ($urandom_range(99) >= IDLE_PCT);
   end

   // monitor: check results first, then predict for newly taken samples
   always @(posedge clock) begin
      detector_out_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            taken_cnt <= taken_cnt + 1;
            if (audio_expected.size() == 0) begin
               error_cnt++;
               if (error_cnt <= 10)
                  $display("unexpected result transfer: data %h last %b", rsp_tdata, rsp_tlast);
            end else begin
               want = audio_expected.pop_front();
               if (rsp_tdata[AUDIO_W-1:0] !== want.audio ||
                   rsp_tlast !== want.blk_end ||
                   rsp_tdata[AUDIO_W+LEVEL_W-1:AUDIO_W] !== want.level) begin
                  error_cnt++;
                  if (error_cnt <= 10)
                     $display("mismatch: audio exp %h got %h, block_end exp %b got %b, level exp %h got %h",
                              want.audio, rsp_tdata[AUDIO_W-1:0], want.blk_end, rsp_tlast,
                              want.level, rsp_tdata[AUDIO_W+LEVEL_W-1:AUDIO_W]);
               end
            end
         end
         if (req_tvalid && req_tready)
            audio_expected.push_back(detect_sample(req_tdata));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         stall_cnt <= 0;
      end else begin
         stall_cnt <= stall_cnt + 1;
         if (stall_cnt >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic send(input int si, input int sq);
      pending_samples.push_back({sq[SAMPLE_W-1:0], si[SAMPLE_W-1:0]});
   endtask

   // wait until every sample is taken and every result has come back
   task automatic drain();
      @(negedge clock);
      while (pending_samples.size() != 0 || req_tvalid || audio_expected.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_DETECT_MODE)
         cfg_mode = val[MODE_W-1:0];
      else
         cfg_len = val[LEN_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic reconfigure(input logic [MODE_W-1:0] mode, input int len);
      drain();
      write_reg(CSR_DETECT_MODE, CSR_W'(mode));
      write_reg(CSR_BLOCK_LEN, CSR_W'(len));
      @(negedge clock);
   endtask

   function automatic int pick_field();
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) begin
         case ($urandom_range(3))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return -1;
         endcase
      end else if (sel < 3) begin
         return $urandom_range(510) - 255;
      end
      return int'($signed(16'($urandom)));
   endfunction

   initial begin
      int rand_sent;
      int burst;
      logic [MODE_W-1:0] mode;
      rand_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration: envelope, long block
      send(32767, -32768);
      send(100, -200);
      send(-32768, -32768);

      reconfigure(MODE_ENV, 4);
      send(0, 0);
      send(32767, 32767);
      send(-1, 1);
      send(-32768, 0);
      send(12345, -23456);

      reconfigure(MODE_USB, 1);
      send(32767, 0);
      send(-32768, -1);
      send(-1, 32767);

      // zero block length behaves as one
      reconfigure(MODE_LSB, 0);
      send(0, -32768);
      send(1, 32767);
      send(-32768, -32768);

      // unused mode gives silent audio and leaves the tracker alone
      reconfigure(MODE_UNUSED, 3);
      send(32767, 32767);
      send(-32768, 5);

      // shortening the block mid-way closes it on the next sample
      reconfigure(MODE_ENV, 8);
      repeat (5) send(pick_field(), pick_field());
      drain();
      write_reg(CSR_BLOCK_LEN, CSR_W'(2));
      @(negedge clock);
      send(-20000, 30000);
      send(7, -7);

      // oversize length is clamped to the maximum block
      reconfigure(MODE_USB, 8191);
      send(-32768, 1);
      send(32767, -1);
      send(-21846, 21845);

      while (rand_sent < 525) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: mode = MODE_ENV;
            5, 6:          mode = MODE_USB;
            7, 8:          mode = MODE_LSB;
            default:       mode = MODE_UNUSED;
         endcase
         reconfigure(mode, ($urandom_range(9) < 7) ? $urandom_range(16, 1)
                                                   : $urandom_range(100, 17));
         burst = $urandom_range(50, 15);
         repeat (burst) begin
            send(pick_field(), pick_field());
            rand_sent++;
            if ($urandom_range(99) < 3)
               drain();
         end
      end

      drain();
      repeat (64) @(posedge clock);
      if (error_cnt == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
